// File: rtl/core/sil_pkg.sv
// Shared types and constants for the subtitle interval lookup block.
// Used by sil_ctrl, sil_datapath and subtitle_interval_lookup.
`default_nettype none

package sil_pkg;

  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int FRAME_W = 32;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [IDX_W-1:0]   entry_index;
    logic [FRAME_W-1:0] start_frame;
    logic [FRAME_W-1:0] end_frame;
    logic [FRAME_W-1:0] query_frame;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] subtitle_index;
    logic             found;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch query frame, set up search bounds
    logic write;     // store one table entry
    logic rd_mid;    // read entry at midpoint
    logic rd_end;    // read entry at lo - 1
    logic step;      // narrow the search bounds
    logic out_load;  // capture result word
    logic out_hit;   // result is a hit
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lo_lt_hi;
    logic lo_zero;
    logic start_gt;
    logic covered;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/sil_datapath.sv
// Datapath: entry table memory, count register, search bounds and result register.
// Depends on sil_pkg; driven by sil_ctrl through cmd_t.
`default_nettype none

module sil_datapath import sil_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire in_word_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data,
  input  wire cmd_t             cmd,
  output status_t               st,
  output out_word_t             out_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [2*FRAME_W-1:0] mem [MAX_ENTRIES];
  logic [2*FRAME_W-1:0] rdata;

  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_eff;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [FRAME_W-1:0] frame;

  logic [CNT_W:0]     sum;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   lo_m1;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               slot_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  // counts above the table depth saturate
  always_comb begin
    if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
      count_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      count_eff = entry_count;
    end
  end

  assign sum     = {1'b0, lo} + {1'b0, hi};
  assign mid     = sum[CNT_W:1];
  assign lo_m1   = lo - 1'b1;
  assign rd_addr = cmd.rd_end ? AW'(lo_m1) : AW'(mid);
  assign wr_addr = AW'(in_data.entry_index);
  assign slot_ok = 32'(in_data.entry_index) < 32'(MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) begin
      mem[wr_addr] <= {in_data.end_frame, in_data.start_frame};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_mid || cmd.rd_end) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      frame <= in_data.query_frame;
      lo    <= '0;
      hi    <= count_eff;
      count <= count_eff;
    end else if (cmd.step) begin
      if (st.start_gt) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.subtitle_index <= cmd.out_hit ? lo_m1 : count;
      out_data.found          <= cmd.out_hit;
    end
  end

  assign st.lo_lt_hi = lo < hi;
  assign st.lo_zero  = (lo == '0);
  assign st.start_gt = rdata[FRAME_W-1:0] > frame;
  assign st.covered  = frame < rdata[2*FRAME_W-1:FRAME_W];

endmodule

`default_nettype wire

// File: rtl/core/sil_ctrl.sv
// Controller: state machine sequencing loads, the binary search and the end check.
// Depends on sil_pkg; commands sil_datapath through cmd_t.
`default_nettype none

module sil_ctrl import sil_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_mode,
  output logic         in_stall,
  input  wire logic    out_stall,
  output logic         out_valid,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_CHK
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (st.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_next = S_CMP;
        end else if (st.lo_zero) begin
          // nothing at or below the frame
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.rd_end = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CMP: begin
        cmd.step   = 1'b1;
        state_next = S_SEARCH;
      end
      S_CHK: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_hit  = st.covered;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_load || (out_valid && out_stall);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while pending");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> $past(state == S_SEARCH && st.lo_lt_hi))
    else $error("compare without a midpoint read");

  a_end_read_lo: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_end |-> !st.lo_zero)
    else $error("end check read below entry zero");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SEARCH || state == S_CHK))
    else $error("result raised outside search end");

endmodule

`default_nettype wire

// File: rtl/core/subtitle_interval_lookup.sv
// Subtitle interval lookup: sorted interval table with binary-search queries.
// Load words write one entry in the cycle they are taken and give no result.
// Queries search the first n table entries, n the effective entry count; each search step
// is one read of the single table read port and one compare. One item is in work at a time.
// Reset (rst, synchronous) clears control state and entry_count; table not cleared.
`default_nettype none

module subtitle_interval_lookup import sil_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  // the user must write the count register only while idle; the block does not enforce it, so always take it
  assign cfg_ready = 1'b1;

  sil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  sil_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: sim/subtitle_interval_lookup_tb.sv
// Self-checking testbench for subtitle_interval_lookup: interval table loads and
// binary-search frame queries, with results checked against an in-bench table model.
// Depends on sil_pkg and the subtitle_interval_lookup RTL only.
module subtitle_interval_lookup_tb;
  import sil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_WORDS   = 70;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  subtitle_interval_lookup #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // table copy and entry count as the block should hold them
  logic [FRAME_W-1:0] start_tab [TABLE_DEPTH];
  logic [FRAME_W-1:0] end_tab [TABLE_DEPTH];
  logic [CNT_W-1:0]   table_count = '0;

  in_word_t  send_words[$];
  out_word_t awaited_lookups[$];
  idle_t     idle_mode = IDLE_NONE;
  bit        in_fire = 1'b0;
  int        queued_total = 0;
  int        taken_total = 0;
  int        lookups_checked = 0;
  int        loads_taken = 0;
  int        counts_written = 0;
  int        errors = 0;
  int        cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned live_entries();
    return (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
  endfunction

  // last entry with start at or below the frame, hit if the frame is before its end
  function automatic out_word_t search_table(input logic [FRAME_W-1:0] frame);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    out_word_t   r;
    n = live_entries();
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (start_tab[mid] > frame) hi = mid;
      else lo = mid + 1;
    end
    if (lo != 0 && frame < end_tab[lo-1]) begin
      r.subtitle_index = CNT_W'(lo - 1);
      r.found = 1'b1;
    end else begin
      r.subtitle_index = CNT_W'(n);
      r.found = 1'b0;
    end
    return r;
  endfunction

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 54;
      IDLE_BOTH: return $urandom_range(0, 99) < 8;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_waits();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 54;
      IDLE_BOTH: return $urandom_range(0, 99) < 8;
      default:   return 1'b0;
    endcase
  endfunction

  // fields a word does not use are filled with noise
  task automatic add_load(input int unsigned slot, input logic [FRAME_W-1:0] s,
                          input logic [FRAME_W-1:0] e);
    in_word_t w;
    w.mode = MODE_LOAD;
    w.entry_index = IDX_W'(slot);
    w.start_frame = s;
    w.end_frame = e;
    w.query_frame = $urandom;
    send_words.push_back(w);
    queued_total++;
  endtask

  task automatic add_query(input logic [FRAME_W-1:0] f);
    in_word_t w;
    w.mode = MODE_QUERY;
    w.entry_index = IDX_W'($urandom);
    w.start_frame = $urandom;
    w.end_frame = $urandom;
    w.query_frame = f;
    send_words.push_back(w);
    queued_total++;
  endtask

  // checked at the falling edge, when both counters and the queue are settled
  task automatic wait_drained();
    while (taken_total != queued_total || awaited_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    table_count = value;
    counts_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // frames near entry edges, inside entries, and anywhere at all
  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned n;
    int unsigned k;
    n = live_entries();
    if (n == 0) return $urandom;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0: return start_tab[k];
      1: return start_tab[k] - 1;
      2: return end_tab[k];
      3: return end_tab[k] - 1;
      4: return start_tab[k] + $urandom_range(0, 3000000);
      5: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  // mostly rewrites that keep the table sorted, some with arbitrary content
  task automatic add_random_load();
    int unsigned       k;
    logic [FRAME_W-1:0] lo_s;
    logic [FRAME_W-1:0] hi_s;
    logic [FRAME_W-1:0] s;
    longint unsigned   span;
    k = $urandom_range(0, TABLE_DEPTH - 1);
    if ($urandom_range(0, 3) != 0) begin
      lo_s = (k == 0) ? '0 : start_tab[k-1];
      hi_s = (k == TABLE_DEPTH - 1) ? '1 : start_tab[k+1];
      if (hi_s < lo_s) begin
        s = lo_s;
      end else begin
        span = longint'(hi_s - lo_s) + 1;
        s = lo_s + FRAME_W'($urandom % span);
      end
      add_load(k, s, s + $urandom_range(0, 3000000));
    end else begin
      add_load(k, $urandom, $urandom);
    end
  endtask

  // driver: next word goes out at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_words.size() != 0 && !sender_waits()) begin
        in_data <= send_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : receiver_waits();
  end

  // monitor: check results, then apply accepted words to the table copy
  always @(posedge clk) begin
    out_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("** subtitle_interval_lookup: FAILED **");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (awaited_lookups.size() == 0) begin
        $display("%0t: result word with none awaited: expected nothing, got index %0d found %0d",
                 $time, out_data.subtitle_index, out_data.found);
        errors++;
      end else begin
        want = awaited_lookups.pop_front();
        if (out_data.subtitle_index !== want.subtitle_index) begin
          $display("%0t: subtitle_index mismatch: expected %0d, got %0d",
                   $time, want.subtitle_index, out_data.subtitle_index);
          errors++;
        end
        if (out_data.found !== want.found) begin
          $display("%0t: found mismatch: expected %0b, got %0b",
                   $time, want.found, out_data.found);
          errors++;
        end
        lookups_checked++;
      end
    end
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      taken_total++;
      if (in_data.mode == MODE_LOAD) begin
        start_tab[in_data.entry_index] = in_data.start_frame;
        end_tab[in_data.entry_index] = in_data.end_frame;
        loads_taken++;
      end else begin
        awaited_lookups.push_back(search_table(in_data.query_frame));
      end
    end
  end

  initial begin
    logic [CNT_W-1:0]   count_val;
    logic [FRAME_W-1:0] s;
    logic [FRAME_W-1:0] e;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table: queries answer index 0, not found
    @(posedge clk);
    add_query('0);
    add_query('1);
    // small table: shared starts, zero length, overlap, end before start, top of range
    add_load(0, 0, 10);
    add_load(1, 10, 10);
    add_load(2, 10, 25);
    add_load(3, 30, 40);
    add_load(4, 35, 100);
    add_load(5, 200, 150);
    add_load(6, 1000, '1);
    add_load(7, '1, '1);
    add_load(TABLE_DEPTH - 1, '1, '1);
    wait_drained();
    write_count(8);
    @(posedge clk);
    add_query(0);
    add_query(9);
    add_query(10);
    add_query(24);
    add_query(25);
    add_query(45);
    add_query(99);
    add_query(100);
    add_query(32'hFFFF_FFFE);
    add_query('1);
    wait_drained();

    // fill the whole table in start order so any count may be searched
    idle_mode = IDLE_SEND;
    @(posedge clk);
    s = $urandom_range(0, 1000);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k > 0) s = s + $urandom_range(0, 4000000);
      case ($urandom_range(0, 3))
        0:       e = s;
        1:       e = s + $urandom_range(1, 2000000);
        2:       e = s + $urandom_range(1, 8000000);
        default: e = s - $urandom_range(0, 1000);
      endcase
      add_load(k, s, e);
    end
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      idle_mode = idle_t'(p % 4);
      case (p)
        0:       count_val = CNT_W'(TABLE_DEPTH);
        1:       count_val = '1;
        2:       count_val = 1;
        3:       count_val = CNT_W'($urandom_range(TABLE_DEPTH + 1, 2046));
        4:       count_val = 2;
        5:       count_val = 0;
        6:       count_val = CNT_W'($urandom_range(3, 63));
        7:       count_val = CNT_W'(TABLE_DEPTH - 1);
        8:       count_val = CNT_W'($urandom_range(64, TABLE_DEPTH - 1));
        9:       count_val = CNT_W'($urandom_range(0, 2047));
        10:      count_val = 3;
        default: count_val = CNT_W'(TABLE_DEPTH / 2);
      endcase
      write_count(count_val);
      @(posedge clk);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 99) < 15) add_random_load();
        else add_query(pick_frame());
      end
      wait_drained();
    end

    $display("checked %0d lookups, with %0d table loads, across %0d entry counts",
             lookups_checked, loads_taken, counts_written);
    $display("idle patterns: none, sender gaps, receiver stalls, both; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("** subtitle_interval_lookup: PASSED **");
    end else begin
      $display("** subtitle_interval_lookup: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sil_pkg.sv
rtl/core/sil_datapath.sv
rtl/core/sil_ctrl.sv
rtl/core/subtitle_interval_lookup.sv
sim/subtitle_interval_lookup_tb.sv
